// ===== sv/weighted_usrcat_similarity_core_defines.svh =====
// Assertion macros for the weighted USRCAT similarity core.
// Used by the top level only; no other dependencies.
`ifndef WEIGHTED_USRCAT_SIMILARITY_CORE_DEFINES_SVH
`define WEIGHTED_USRCAT_SIMILARITY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WUSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define WUSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WUSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WUSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/wusc_pkg.sv =====
// Shared types and constants of the weighted USRCAT similarity core.
// No dependencies; imported by every module of the block.
package wusc_pkg;

  localparam int VAL_W   = 24;  // Q8.16 element
  localparam int WGT_W   = 16;  // Q4.12 weight
  localparam int PROD_W  = VAL_W + WGT_W;
  localparam int SUM_W   = 48;  // weighted sum, scale 2^-28
  localparam int CNT_W   = 7;   // element count
  localparam int SIM_W   = 17;  // Q1.16 score, 65536 is 1.0
  localparam int NUM_SEG = 5;
  localparam int IDX_W   = 3;   // configuration register index
  localparam int CFG_W   = 16;  // widest register

  localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(4096);

  // division N*2^44 / (N*2^28 + S), quotient fits in SIM_W bits
  localparam int NUM_SHIFT = 44;
  localparam int DEN_SHIFT = 28;
  localparam int DEN_W     = SUM_W + 1;
  localparam int REM_W     = DEN_W + SIM_W;
  localparam int STEP_W    = 5;

  // queue between accumulator and divider
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_USE_WEIGHTS     = 3'd0,
    REG_WGT_ALL         = 3'd1,
    REG_WGT_HYDROPHOBIC = 3'd2,
    REG_WGT_AROMATIC    = 3'd3,
    REG_WGT_ACCEPTOR    = 3'd4,
    REG_WGT_DONOR       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                          use_weights;
    logic [NUM_SEG-1:0][WGT_W-1:0] weight;
  } cfg_t;

  // one finished vector waiting for the divide
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/wusc_front.sv =====
// Accumulator front end: a pair a cycle unless stalled; weights and sums it.
// Depends on wusc_pkg; feeds finished vectors to wusc_queue.
module wusc_front import wusc_pkg::*; #(
  parameter int SEGMENT_LEN  = 12,
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] first_value_i,
  input  logic signed [VAL_W-1:0] second_value_i,
  input  logic                    last_pair_i,
  input  q_stat_t                 q_stat_i,
  output logic                    push_o,
  output job_t                    job_o
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  logic                    adv, accept;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
  logic signed [VAL_W:0]   sub;
  logic [VAL_W-1:0]        abs_diff;
  logic [WGT_W-1:0]        wgt_sel;

  logic                    s1_valid_q, s1_last_q;
  logic [VAL_W-1:0]        s1_diff_q;
  logic [WGT_W-1:0]        s1_wgt_q;
  logic [CNT_W-1:0]        s1_n_q;

  logic                    s2_valid_q, s2_last_q;
  logic [PROD_W-1:0]       s2_prod_q;
  logic [CNT_W-1:0]        s2_n_q;

  logic [SUM_W-1:0]        sum_q, sum_d, sum_tot;
  logic [SUM_W:0]          sum_ext;

  // pipeline moves unless a last pair meets a full queue
  assign adv        = !(s2_valid_q && s2_last_q && q_stat_i.full);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // element count, saturating
  assign cnt_inc = (cnt_q < MAX_CNT) ? cnt_q + 1'b1 : cnt_q;
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last_pair_i ? '0 : cnt_inc;
    end
  end

  // absolute difference of the pair
  assign sub      = {first_value_i[VAL_W-1], first_value_i}
                  - {second_value_i[VAL_W-1], second_value_i};
  assign abs_diff = sub[VAL_W] ? VAL_W'(-sub) : sub[VAL_W-1:0];

  // segment weight: lowest segment whose end lies above the index wins
  always_comb begin
    wgt_sel = '0;
    if (!cfg_i.use_weights) begin
      wgt_sel = WEIGHT_ONE;
    end else begin
      for (int s = NUM_SEG - 1; s >= 0; s--) begin
        if (cnt_q < CNT_W'((s + 1) * SEGMENT_LEN)) begin
          wgt_sel = cfg_i.weight[s];
        end
      end
    end
  end

  // accumulate as stage 2 retires; saturate at full scale
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(s2_prod_q);
  assign sum_tot = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_comb begin
    sum_d = sum_q;
    if (adv && s2_valid_q) begin
      sum_d = s2_last_q ? '0 : sum_tot;
    end
  end

  assign push_o    = adv && s2_valid_q && s2_last_q;
  assign job_o.n   = s2_n_q;
  assign job_o.sum = sum_tot;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      if (adv) begin
        s1_valid_q <= accept;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload stages: difference and weight, then product
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_diff_q <= abs_diff;
      s1_wgt_q  <= wgt_sel;
      s1_last_q <= last_pair_i;
      s1_n_q    <= cnt_inc;
      s2_prod_q <= PROD_W'(s1_diff_q) * PROD_W'(s1_wgt_q);
      s2_last_q <= s1_last_q;
      s2_n_q    <= s1_n_q;
    end
  end

endmodule

// ===== sv/wusc_queue.sv =====
// Short queue of finished vectors between accumulator and divider.
// Depends on wusc_pkg.
module wusc_queue import wusc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] fill_q;

  assign job_o        = mem_q[rd_q];
  assign stat_o.full  = (fill_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (fill_q == '0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== sv/wusc_divider.sv =====
// Back end: restoring divider for N*2^44 / (N*2^28 + S), one quotient bit a
// cycle, with the result register. Depends on wusc_pkg.
module wusc_divider import wusc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  job_t             job_i,
  input  q_stat_t          q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [SIM_W-1:0] similarity_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } div_state_e;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIM_W - 1);

  div_state_e        state_q;
  logic [REM_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [SIM_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic [SIM_W-1:0]  sim_q;

  logic [REM_W:0]    trial;
  logic              ge;
  logic [DEN_W-1:0]  den_load;
  logic              out_free;

  assign pop_o    = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign out_free = !out_valid_q || !out_stall_i;

  // denominator N*2^28 + S
  assign den_load = (DEN_W'(job_i.n) << DEN_SHIFT) + DEN_W'(job_i.sum);

  // trial subtract of the denominator aligned to the top quotient bit
  assign trial = {1'b0, rem_q} - {2'b00, den_q, {(SIM_W - 1){1'b0}}};
  assign ge    = !trial[REM_W];

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // result register: load on handoff, clear once taken
      if ((state_q == ST_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            rem_q   <= REM_W'(job_i.n) << NUM_SHIFT;
            den_q   <= den_load;
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem_q  <= ge ? {trial[REM_W-2:0], 1'b0} : {rem_q[REM_W-2:0], 1'b0};
          quo_q  <= {quo_q[SIM_W-2:0], ge};
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            sim_q   <= quo_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/weighted_usrcat_similarity_core.sv =====
// Top level of the weighted USRCAT similarity core: configuration registers,
// accumulator front end, queue and divider. Depends on wusc_pkg and the defines.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+----------------------------------
//  in       | in_valid_i / in_stall_o      | first_value_i, second_value_i,
//           |                              | last_pair_i
//  out      | out_valid_o / out_stall_i    | similarity_o
//  cfg      | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//
// One element pair is taken per cycle unless in_stall_o is high; registers
// hold difference and weight, then product, then sum. The single-bit restoring
// divider loads a vector, forms 17 quotient bits and hands off its score before
// the next, so it paces short vectors; a two-entry queue absorbs bursts.
// Reset restores the register defaults and clears the sum and count.
// in_stall_o rises only when a last pair finds the queue full; out_stall_i
// holds the result register and, through it, the divider.
`include "weighted_usrcat_similarity_core_defines.svh"

module weighted_usrcat_similarity_core import wusc_pkg::*; #(
  parameter int SEGMENT_LEN  = 12,
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] first_value_i,
  input  logic signed [VAL_W-1:0] second_value_i,
  input  logic                    last_pair_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SIM_W-1:0]        similarity_o
);

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, pop_job;

  // register writes; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_USE_WEIGHTS: begin
          cfg_d.use_weights = cfg_data_i[0];
        end
        REG_WGT_ALL, REG_WGT_HYDROPHOBIC, REG_WGT_AROMATIC,
        REG_WGT_ACCEPTOR, REG_WGT_DONOR: begin
          cfg_d.weight[cfg_index_i - 1'b1] = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_weights <= 1'b1;
      cfg_q.weight      <= {NUM_SEG{WEIGHT_ONE}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wusc_front #(
    .SEGMENT_LEN  (SEGMENT_LEN),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .last_pair_i    (last_pair_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .job_o          (push_job)
  );

  wusc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .stat_o (q_stat)
  );

  wusc_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (pop_job),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .similarity_o (similarity_o)
  );

  // checks
  `WUSC_ASSERT_IMP(a_push_room, clk_i, rst_ni, push, !q_stat.full, "push into full queue")
  `WUSC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !q_stat.full, !in_stall_o, "stall with queue room")
  `WUSC_ASSERT_IMP(a_sim_range, clk_i, rst_ni, out_valid_o, similarity_o <= 17'd65536, "score above one")
  `WUSC_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, pop && !push, !q_stat.full, "queue full after pop")

endmodule
